// ----- hdl/bgd_pkg.sv -----
// ----------------------------------------------------------------------------
// bgd_pkg
// Types and constants shared by the button gesture detector.
// ----------------------------------------------------------------------------
package bgd_pkg;

	typedef enum logic [3:0] {
		ST_IDLE        = 4'd0,
		ST_DOWN_DB     = 4'd1,
		ST_DOWN        = 4'd2,
		ST_LONG        = 4'd3,
		ST_LONG_DB     = 4'd4,
		ST_UP_DB       = 4'd5,
		ST_UP          = 4'd6,
		ST_DBL_DOWN_DB = 4'd7,
		ST_DBL_DOWN    = 4'd8,
		ST_DBL_UP_DB   = 4'd9
	} state_t;

	typedef enum logic [2:0] {
		G_NONE   = 3'd0,
		G_DOWN   = 3'd1,
		G_UP     = 3'd2,
		G_CLICK  = 3'd3,
		G_LONG   = 3'd4,
		G_DOUBLE = 3'd5,
		G_IDLE   = 3'd6
	} gesture_t;

	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned TimeW    = 32;

	localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE   = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_IDLE_TMO   = 2'd2;

	localparam logic [CfgDataW-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [CfgDataW-1:0] LONG_PRESS_RST = 16'd1500;
	localparam logic [CfgDataW-1:0] IDLE_TMO_RST   = 16'd200;

	typedef struct packed {
		logic [CfgDataW-1:0] debounce_ms;
		logic [CfgDataW-1:0] long_press_ms;
		logic [CfgDataW-1:0] idle_timeout_ms;
	} cfg_t;

	typedef struct packed {
		state_t             phase;
		logic               ref_load;
		gesture_t           gesture;
	} step_t;

endpackage

// ----- hdl/bgd_step.sv -----
// ----------------------------------------------------------------------------
// bgd_step
// One scan of the gesture state machine: threshold compare and next state.
// ----------------------------------------------------------------------------
module bgd_step (
	input  bgd_pkg::state_t             phase,
	input  logic [bgd_pkg::TimeW-1:0]   ref_time,
	input  bgd_pkg::cfg_t               cfg,
	input  logic                        key_level,
	input  logic [bgd_pkg::TimeW-1:0]   now_ms,
	output bgd_pkg::step_t              step
);
	import bgd_pkg::*;

	logic                pressed;
	logic [CfgDataW-1:0] limit;
	logic [TimeW-1:0]    elapsed;
	logic                passed;

	assign pressed = ~key_level;
	assign elapsed = now_ms - ref_time;
	assign passed  = elapsed > {{(TimeW-CfgDataW){1'b0}}, limit};

	always_comb begin
		unique case (phase)
			ST_DOWN, ST_DBL_DOWN: limit = cfg.long_press_ms;
			ST_UP:                limit = cfg.idle_timeout_ms;
			default:              limit = cfg.debounce_ms;
		endcase
	end

	always_comb begin
		step.phase    = phase;
		step.ref_load = 1'b0;
		step.gesture  = G_NONE;
		unique case (phase)
			ST_IDLE: begin
				if (pressed) begin
					step.ref_load = 1'b1;
					step.phase    = ST_DOWN_DB;
				end
			end
			ST_DOWN_DB: begin
				if (!pressed) begin
					step.phase = ST_IDLE;
				end else if (passed) begin
					step.ref_load = 1'b1;
					step.phase    = ST_DOWN;
					step.gesture  = G_DOWN;
				end
			end
			ST_DOWN: begin
				if (!pressed) begin
					step.ref_load = 1'b1;
					step.phase    = ST_UP_DB;
				end else if (passed) begin
					step.phase   = ST_LONG;
					step.gesture = G_LONG;
				end
			end
			ST_LONG: begin
				if (!pressed) begin
					step.ref_load = 1'b1;
					step.phase    = ST_LONG_DB;
				end
			end
			ST_LONG_DB: begin
				if (pressed) begin
					step.phase = ST_LONG;
				end else if (passed) begin
					step.ref_load = 1'b1;
					step.phase    = ST_IDLE;
					step.gesture  = G_IDLE;
				end
			end
			ST_UP_DB: begin
				if (pressed) begin
					step.phase = ST_DOWN;
				end else if (passed) begin
					step.phase   = ST_UP;
					step.gesture = G_UP;
				end
			end
			ST_UP: begin
				if (pressed) begin
					step.ref_load = 1'b1;
					step.phase    = ST_DBL_DOWN_DB;
				end else if (passed) begin
					step.phase   = ST_IDLE;
					step.gesture = G_CLICK;
				end
			end
			ST_DBL_DOWN_DB: begin
				if (!pressed) begin
					step.phase = ST_UP;
				end else if (passed) begin
					step.ref_load = 1'b1;
					step.phase    = ST_DBL_DOWN;
				end
			end
			ST_DBL_DOWN: begin
				if (!pressed) begin
					step.ref_load = 1'b1;
					step.phase    = ST_DBL_UP_DB;
				end else if (passed) begin
					step.ref_load = 1'b1;
					step.phase    = ST_LONG;
					step.gesture  = G_LONG;
				end
			end
			ST_DBL_UP_DB: begin
				if (pressed) begin
					step.phase = ST_DBL_DOWN;
				end else if (passed) begin
					step.ref_load = 1'b1;
					step.phase    = ST_IDLE;
					step.gesture  = G_DOUBLE;
				end
			end
			default: begin
				step.phase = phase;
			end
		endcase
	end

endmodule

// ----- hdl/button_gesture_detector.sv -----
// ----------------------------------------------------------------------------
// button_gesture_detector
// Click, double-click and long-press recognizer for one active-low button.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one word per button scan (level and ms timestamp).
//   Master stream: one word per scan (gesture code and state after the scan).
//   cfg_we/cfg_idx/cfg_data write the debounce, long-press and idle
//   thresholds; write them only while no scan is in flight.
// Timing:
//   A scan is held in the input register, where the state machine step
//   (one 32-bit subtract and compare) runs, then lands in the output
//   register, which drives m_tvalid and m_tdata. One scan per cycle is
//   sustained while m_tready stays high.
// Reset:
//   arst_n clears both registers and the detector state (idle, reference
//   time zero) and loads the threshold defaults 50, 1500 and 200 ms.
// Stall:
//   While m_tready is low the result holds; one more scan is taken into the
//   input register, then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module button_gesture_detector (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [39:0]                     s_tdata,  // key_level, now_ms
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,  // gesture, fsm_state
	input  logic                            cfg_we,
	input  logic [bgd_pkg::CfgIdxW-1:0]     cfg_idx,
	input  logic [bgd_pkg::CfgDataW-1:0]    cfg_data
);
	import bgd_pkg::*;

	cfg_t             cfg_q;
	state_t           phase_q;
	logic [TimeW-1:0] ref_time_q;

	logic             valid_s1;
	logic             key_s1;
	logic [TimeW-1:0] now_s1;

	logic             valid_s2;
	gesture_t         gesture_s2;
	state_t           state_s2;

	logic             out_free;
	logic             fire_s1;
	step_t            step;

	assign out_free = !valid_s2 || m_tready;
	assign fire_s1  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms     <= DEBOUNCE_RST;
			cfg_q.long_press_ms   <= LONG_PRESS_RST;
			cfg_q.idle_timeout_ms <= IDLE_TMO_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_DEBOUNCE:   cfg_q.debounce_ms     <= cfg_data;
				CFG_LONG_PRESS: cfg_q.long_press_ms   <= cfg_data;
				CFG_IDLE_TMO:   cfg_q.idle_timeout_ms <= cfg_data;
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			key_s1 <= s_tdata[0];
			now_s1 <= s_tdata[TimeW:1];
		end
	end

	bgd_step u_step (
		.phase     (phase_q),
		.ref_time  (ref_time_q),
		.cfg       (cfg_q),
		.key_level (key_s1),
		.now_ms    (now_s1),
		.step      (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= ST_IDLE;
			ref_time_q <= '0;
			state_s2   <= ST_IDLE;
			gesture_s2 <= G_NONE;
		end else if (fire_s1) begin
			phase_q    <= step.phase;
			state_s2   <= step.phase;
			gesture_s2 <= step.gesture;
			if (step.ref_load) begin
				ref_time_q <= now_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, state_s2, gesture_s2};

`ifndef SYNTHESIS
	a_state_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> state_s2 == phase_q)
		else $error("output state differs from detector state");

	a_double_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && step.gesture == G_DOUBLE |=> phase_q == ST_IDLE && ref_time_q == $past(now_s1))
		else $error("double click did not return to idle with new reference");

	a_long_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && gesture_s2 == G_LONG |-> state_s2 == ST_LONG)
		else $error("long press reported outside long state");

	a_ref_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> $stable(ref_time_q) && $stable(phase_q))
		else $error("detector state moved without a scan");
`endif

endmodule

// ----- test/bgd_scan_checker.sv -----
// ----------------------------------------------------------------------------
// bgd_scan_checker
// Watches the scan and result streams of the button gesture detector, keeps
// its own copy of the detector state and thresholds, predicts the gesture
// and state for every accepted scan word and compares each result word with
// the oldest prediction still due.
// ----------------------------------------------------------------------------
module bgd_scan_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [39:0]                  s_tdata,  // key_level, now_ms
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [7:0]                   m_tdata,  // gesture, fsm_state
	input  logic                         cfg_we,
	input  logic [bgd_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [bgd_pkg::CfgDataW-1:0] cfg_data,
	output int                           fails,
	output int                           pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import bgd_pkg::*;

	typedef struct packed {
		gesture_t g;
		state_t   st;
	} scan_result_t;

	state_t              det_state;
	logic [TimeW-1:0]    ref_ms;
	logic [CfgDataW-1:0] deb_ms;
	logic [CfgDataW-1:0] long_ms;
	logic [CfgDataW-1:0] idle_ms;
	scan_result_t        due_results[$];
	int                  n_bad = 0;
	int                  n_seen = 0;

	initial begin
		fails = 0;
		pending = 0;
	end

	function automatic logic held_past(input logic [TimeW-1:0] now_ms,
			input logic [CfgDataW-1:0] limit);
		logic [TimeW-1:0] span;
		span = now_ms - ref_ms;
		return span > {16'd0, limit};
	endfunction

	// one scan of the gesture state machine
	function automatic gesture_t advance_detector(input logic pressed,
			input logic [TimeW-1:0] now_ms);
		gesture_t g;
		g = G_NONE;
		case (det_state)
		ST_IDLE: if (pressed) begin
			ref_ms = now_ms;
			det_state = ST_DOWN_DB;
		end
		ST_DOWN_DB: if (!pressed) begin
			det_state = ST_IDLE;
		end else if (held_past(now_ms, deb_ms)) begin
			ref_ms = now_ms;
			det_state = ST_DOWN;
			g = G_DOWN;
		end
		ST_DOWN: if (!pressed) begin
			ref_ms = now_ms;
			det_state = ST_UP_DB;
		end else if (held_past(now_ms, long_ms)) begin
			det_state = ST_LONG;
			g = G_LONG;
		end
		ST_LONG: if (!pressed) begin
			ref_ms = now_ms;
			det_state = ST_LONG_DB;
		end
		ST_LONG_DB: if (pressed) begin
			det_state = ST_LONG;
		end else if (held_past(now_ms, deb_ms)) begin
			ref_ms = now_ms;
			det_state = ST_IDLE;
			g = G_IDLE;
		end
		ST_UP_DB: if (pressed) begin
			det_state = ST_DOWN;
		end else if (held_past(now_ms, deb_ms)) begin
			det_state = ST_UP;
			g = G_UP;
		end
		ST_UP: if (pressed) begin
			ref_ms = now_ms;
			det_state = ST_DBL_DOWN_DB;
		end else if (held_past(now_ms, idle_ms)) begin
			det_state = ST_IDLE;
			g = G_CLICK;
		end
		ST_DBL_DOWN_DB: if (!pressed) begin
			det_state = ST_UP;
		end else if (held_past(now_ms, deb_ms)) begin
			ref_ms = now_ms;
			det_state = ST_DBL_DOWN;
		end
		ST_DBL_DOWN: if (!pressed) begin
			ref_ms = now_ms;
			det_state = ST_DBL_UP_DB;
		end else if (held_past(now_ms, long_ms)) begin
			ref_ms = now_ms;
			det_state = ST_LONG;
			g = G_LONG;
		end
		ST_DBL_UP_DB: if (pressed) begin
			det_state = ST_DBL_DOWN;
		end else if (held_past(now_ms, deb_ms)) begin
			ref_ms = now_ms;
			det_state = ST_IDLE;
			g = G_DOUBLE;
		end
		default: ;
		endcase
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		scan_result_t want;
		if (!arst_n) begin
			det_state = ST_IDLE;
			ref_ms = '0;
			deb_ms = DEBOUNCE_RST;
			long_ms = LONG_PRESS_RST;
			idle_ms = IDLE_TMO_RST;
			due_results.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
				CFG_DEBOUNCE:   deb_ms = cfg_data;
				CFG_LONG_PRESS: long_ms = cfg_data;
				CFG_IDLE_TMO:   idle_ms = cfg_data;
				default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				n_seen++;
				if (due_results.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("result word %0d arrived with nothing due: %h", n_seen, m_tdata);
				end else begin
					want = due_results.pop_front();
					if (m_tdata[2:0] !== want.g || m_tdata[6:3] !== want.st ||
							m_tdata[7] !== 1'b0) begin
						n_bad++;
						if (n_bad <= 10)
							$display("result word %0d: gesture exp %0d got %0d, state exp %0d got %0d, pad %b",
								n_seen, want.g, m_tdata[2:0], want.st, m_tdata[6:3], m_tdata[7]);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				want.g = advance_detector(~s_tdata[0], s_tdata[32:1]);
				want.st = det_state;
				due_results.push_back(want);
			end
			pending <= due_results.size();
		end
		fails <= n_bad;
	end

endmodule

// ----- test/tb_button_gesture_detector.sv -----
// ----------------------------------------------------------------------------
// tb_button_gesture_detector
// Drives button scan words into the gesture detector under several threshold
// settings: a directed walk through every gesture, time wrap and re-press
// case, then press/release bursts with random timing, noise and timestamp
// jumps, with random gaps and stalls on both streams. The checker judges
// every result word.
// ----------------------------------------------------------------------------
module tb_button_gesture_detector;
	timeunit 1ns;
	timeprecision 1ps;
	import bgd_pkg::*;

	localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 200000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [39:0]         s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [7:0]          m_tdata;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_idx = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	int                  fails;
	int                  pending;

	int                  idle_pct = 32;
	int                  cycle_cnt = 0;
	int                  n_sent = 0;
	int                  n_settings = 1;
	int unsigned         deb_ms = 50;
	int unsigned         long_ms = 1500;
	int unsigned         idle_ms = 200;
	logic [TimeW-1:0]    t_now = '0;

	button_gesture_detector dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	bgd_scan_checker scan_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.fails    (fails),
		.pending  (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= idle_pct);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb_button_gesture_detector failed");
			$finish;
		end
	end

	task automatic send_scan(input logic key, input logic [TimeW-1:0] stamp);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= {7'd0, stamp, key};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_thresholds(input int unsigned deb, input int unsigned lng,
			input int unsigned idl);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_DEBOUNCE;
		cfg_data <= 16'(deb);
		@(posedge clk);
		cfg_idx <= CFG_LONG_PRESS;
		cfg_data <= 16'(lng);
		@(posedge clk);
		cfg_idx <= CFG_IDLE_TMO;
		cfg_data <= 16'(idl);
		@(posedge clk);
		// unused index, must not disturb anything
		cfg_idx <= CFG_SPARE;
		cfg_data <= 16'($urandom());
		@(posedge clk);
		cfg_we <= 1'b0;
		deb_ms = deb;
		long_ms = lng;
		idle_ms = idl;
		n_settings++;
		@(posedge clk);
	endtask

	// mostly press/release holds of chosen length, plus noise and time jumps
	task automatic random_scans(input int n_scans, input int n_calm);
		int               sent;
		int unsigned      pick;
		int unsigned      span;
		int unsigned      steps;
		logic             lvl;
		sent = 0;
		lvl = 1'b1;
		while (sent < n_scans) begin
			idle_pct = (sent < n_calm) ? 0 : 32;
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				if ($urandom_range(0, 3) != 0)
					lvl = ~lvl;
				case ($urandom_range(0, 3))
				0: span = $urandom_range(0, deb_ms);
				1: span = deb_ms + $urandom_range(1, idle_ms + 2);
				2: span = long_ms + $urandom_range(1, 2 * deb_ms + 10);
				default: span = $urandom_range(0, long_ms + idle_ms + 2);
				endcase
				steps = $urandom_range(1, 5);
				repeat (steps) begin
					t_now += span / steps + $urandom_range(0, 2);
					send_scan(lvl, t_now);
				end
				sent += steps;
			end else if (pick < 92) begin
				t_now += $urandom_range(0, 3 * deb_ms + 5);
				send_scan(1'($urandom_range(0, 1)), t_now);
				sent++;
			end else begin
				t_now = $urandom();
				send_scan(1'($urandom_range(0, 1)), t_now);
				sent++;
			end
		end
		idle_pct = 32;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default thresholds: 50 / 1500 / 200
		send_scan(1'b1, 32'd0);
		send_scan(1'b0, 32'd100);
		send_scan(1'b0, 32'd150);           // exactly at debounce, not past
		send_scan(1'b0, 32'd151);           // down
		send_scan(1'b1, 32'd200);
		send_scan(1'b0, 32'd210);           // bounce back during up debounce
		send_scan(1'b1, 32'd300);
		send_scan(1'b1, 32'd351);           // up
		send_scan(1'b0, 32'd400);
		send_scan(1'b1, 32'd420);           // second press too short
		send_scan(1'b0, 32'd430);
		send_scan(1'b0, 32'd500);           // double down
		send_scan(1'b1, 32'd510);
		send_scan(1'b0, 32'd520);           // re-press in double-up debounce
		send_scan(1'b1, 32'd530);
		send_scan(1'b1, 32'd600);           // double click
		send_scan(1'b0, 32'hFFFF_FF00);
		send_scan(1'b0, 32'h0000_0100);     // down across the wrap
		send_scan(1'b0, 32'h0000_0200);
		send_scan(1'b0, 32'h0000_0000);     // time runs backwards: long press
		send_scan(1'b1, 32'hFFFF_FFFF);
		send_scan(1'b0, 32'd5);             // back to long pressed
		send_scan(1'b1, 32'd10);
		send_scan(1'b1, 32'd100);           // idle after long
		send_scan(1'b0, 32'd200);
		send_scan(1'b0, 32'd300);
		send_scan(1'b1, 32'd310);
		send_scan(1'b1, 32'd400);           // up, idle timed from release
		send_scan(1'b1, 32'd700);           // click
		t_now = 32'd700;
		random_scans(420, 0);
		drain();

		program_thresholds(3, 20, 10);
		random_scans(300, 200);
		drain();

		program_thresholds(0, 0, 0);
		random_scans(200, 0);
		drain();

		program_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_scans(200, 0);
		drain();

		program_thresholds(12, 150, 60);
		random_scans(250, 0);
		drain();

		program_thresholds(2, 8, 16'hFFFF);
		random_scans(150, 0);
		drain();

		$display("%0d scans under %0d threshold settings, incl. wrapped and jumping timestamps",
			n_sent, n_settings);
		$display("random gaps and stalls on both streams, %0d mismatches", fails);
		if (pending != 0)
			$display("%0d result words never arrived", pending);
		if (fails == 0 && pending == 0) begin
			$display("tb_button_gesture_detector passed");
		end else begin
			$display("tb_button_gesture_detector failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/bgd_pkg.sv
hdl/bgd_step.sv
hdl/button_gesture_detector.sv
test/bgd_scan_checker.sv
test/tb_button_gesture_detector.sv
